// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the bounding box block.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/bbc_pkg.sv =====
// Shared constants and types for the bounding box and centroid block.
// Depends on nothing; used by every module under hw/rtl.
package bbc_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_POINTS = 65535;
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int SUM_BITS   = COORD_BITS + CNT_BITS;
  localparam int AXES       = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int STEP_BITS  = $clog2(SUM_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  // One finished set, handed from the accumulator to the divider.
  typedef struct packed {
    logic [AXES-1:0][SUM_BITS-1:0]   sum;
    logic [AXES-1:0][COORD_BITS-1:0] box_min;
    logic [AXES-1:0][COORD_BITS-1:0] box_max;
    cnt_t                            count;
  } set_rec_t;

endpackage

// ===== hw/rtl/bbc_front.sv =====
// Point accumulator: box, running sums, count and first point of the open set.
// Depends on bbc_pkg; pushes one record per finished set into bbc_fifo.
`include "assert_macros.svh"

module bbc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [bbc_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [bbc_pkg::COORD_BITS-1:0] point_y,
  input  logic signed [bbc_pkg::COORD_BITS-1:0] point_z,
  input  logic                               last_point,
  input  logic                               push,
  output logic                               full,
  output logic                               q_wr,
  output bbc_pkg::set_rec_t                  q_wr_data,
  input  logic                               q_full
);

  bbc_pkg::coord_t p        [bbc_pkg::AXES];
  bbc_pkg::coord_t first    [bbc_pkg::AXES];
  bbc_pkg::coord_t box_lo   [bbc_pkg::AXES];
  bbc_pkg::coord_t box_hi   [bbc_pkg::AXES];
  bbc_pkg::sum_t   sum      [bbc_pkg::AXES];
  bbc_pkg::coord_t lo_next  [bbc_pkg::AXES];
  bbc_pkg::coord_t hi_next  [bbc_pkg::AXES];
  bbc_pkg::sum_t   sum_next [bbc_pkg::AXES];
  bbc_pkg::cnt_t   count;
  bbc_pkg::cnt_t   count_next;
  logic            accept;
  logic            open;
  logic            loop;
  logic            add;

  assign p[0]   = point_x;
  assign p[1]   = point_y;
  assign p[2]   = point_z;
  assign full   = q_full;
  assign accept = push && !q_full;
  assign open   = (count != '0);
  assign q_wr   = accept && last_point;

  always_comb begin
    loop = open && last_point && (p[0] == first[0]) && (p[1] == first[1]) &&
           (p[2] == first[2]);
    add  = !loop && (count < bbc_pkg::CNT_BITS'(bbc_pkg::MAX_POINTS));
    for (int a = 0; a < bbc_pkg::AXES; a++) begin
      if (!open) begin
        lo_next[a] = p[a];
        hi_next[a] = p[a];
      end else begin
        lo_next[a] = (p[a] < box_lo[a]) ? p[a] : box_lo[a];
        hi_next[a] = (p[a] > box_hi[a]) ? p[a] : box_hi[a];
      end
      // a new set starts from zero whatever the sum register holds
      sum_next[a] = (open ? sum[a] : '0) +
                    (add ? {{bbc_pkg::CNT_BITS{p[a][bbc_pkg::COORD_BITS-1]}}, p[a]} : '0);
    end
    count_next = count + bbc_pkg::CNT_BITS'(add);
  end

  always_comb begin
    for (int a = 0; a < bbc_pkg::AXES; a++) begin
      q_wr_data.sum[a]     = sum_next[a];
      q_wr_data.box_min[a] = lo_next[a];
      q_wr_data.box_max[a] = hi_next[a];
    end
    q_wr_data.count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= last_point ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < bbc_pkg::AXES; a++) begin
        sum[a]    <= sum_next[a];
        box_lo[a] <= lo_next[a];
        box_hi[a] <= hi_next[a];
        if (!open) begin
          first[a] <= p[a];
        end
      end
    end
  end

  `CHK_NEXT(a_close_clears, clk, rst, accept && last_point, count == '0, "set not closed")
  `CHK_NEXT(a_open_counts, clk, rst, accept && !open && !last_point, count == bbc_pkg::CNT_BITS'(1), "first point not counted")
  `CHK_IMPL(a_single_point, clk, rst, accept && last_point && !open, q_wr_data.count == bbc_pkg::CNT_BITS'(1), "single point set miscounted")

endmodule

// ===== hw/rtl/bbc_fifo.sv =====
// Small queue of finished-set records between accumulator and divider.
// Depends on bbc_pkg; read data is registered and valid in the cycle after rd_en.
module bbc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  bbc_pkg::set_rec_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output bbc_pkg::set_rec_t rd_data,
  output logic              empty
);

  bbc_pkg::set_rec_t                mem [bbc_pkg::Q_DEPTH];
  logic [bbc_pkg::Q_PTR_BITS-1:0]   wr_ptr;
  logic [bbc_pkg::Q_PTR_BITS-1:0]   rd_ptr;
  logic [bbc_pkg::Q_PTR_BITS:0]     fill;

  assign full  = (fill == (bbc_pkg::Q_PTR_BITS + 1)'(bbc_pkg::Q_DEPTH));
  assign empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

endmodule

// ===== hw/rtl/bbc_back.sv =====
// Centroid divider and result register: three restoring dividers, one bit each per cycle.
// Depends on bbc_pkg; takes records from bbc_fifo and drives the result ports.
`include "assert_macros.svh"

module bbc_back (
  input  logic                                  clk,
  input  logic                                  rst,
  output logic                                  q_rd,
  input  bbc_pkg::set_rec_t                     q_rd_data,
  input  logic                                  q_empty,
  output logic signed [bbc_pkg::COORD_BITS-1:0] center_x,
  output logic signed [bbc_pkg::COORD_BITS-1:0] center_y,
  output logic signed [bbc_pkg::COORD_BITS-1:0] center_z,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_min_x,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_min_y,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_min_z,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_max_x,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_max_y,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_max_z,
  output logic        [bbc_pkg::CNT_BITS-1:0]   counted_points,
  output logic                                  empty,
  input  logic                                  pop
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_HOLD} state_t;

  state_t                          state;
  logic [bbc_pkg::SUM_BITS-1:0]    dvd      [bbc_pkg::AXES];
  bbc_pkg::cnt_t                   rem      [bbc_pkg::AXES];
  logic                            neg      [bbc_pkg::AXES];
  logic [bbc_pkg::SUM_BITS-1:0]    dvd_next [bbc_pkg::AXES];
  bbc_pkg::cnt_t                   rem_next [bbc_pkg::AXES];
  bbc_pkg::coord_t                 quot     [bbc_pkg::AXES];
  logic [bbc_pkg::CNT_BITS:0]      trial    [bbc_pkg::AXES];
  logic [bbc_pkg::CNT_BITS:0]      diff     [bbc_pkg::AXES];
  logic [bbc_pkg::STEP_BITS-1:0]   step;
  bbc_pkg::cnt_t                   divisor;
  bbc_pkg::set_rec_t               held;
  logic                            out_valid;
  logic                            hand;

  assign q_rd  = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;
  // hand over once the result register is free or being drained
  assign hand  = (state == S_HOLD) && (!out_valid || pop);

  // one restoring step per lane, quotient bits shift in behind the dividend
  always_comb begin
    for (int a = 0; a < bbc_pkg::AXES; a++) begin
      trial[a] = {rem[a], dvd[a][bbc_pkg::SUM_BITS-1]};
      diff[a]  = trial[a] - {1'b0, divisor};
      if (trial[a] >= {1'b0, divisor}) begin
        rem_next[a] = diff[a][bbc_pkg::CNT_BITS-1:0];
        dvd_next[a] = {dvd[a][bbc_pkg::SUM_BITS-2:0], 1'b1};
      end else begin
        rem_next[a] = trial[a][bbc_pkg::CNT_BITS-1:0];
        dvd_next[a] = {dvd[a][bbc_pkg::SUM_BITS-2:0], 1'b0};
      end
      quot[a] = neg[a] ? bbc_pkg::COORD_BITS'(-dvd[a]) : bbc_pkg::COORD_BITS'(dvd[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (hand) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int a = 0; a < bbc_pkg::AXES; a++) begin
            neg[a] <= q_rd_data.sum[a][bbc_pkg::SUM_BITS-1];
            dvd[a] <= q_rd_data.sum[a][bbc_pkg::SUM_BITS-1] ? -q_rd_data.sum[a]
                                                             : q_rd_data.sum[a];
            rem[a] <= '0;
          end
          divisor <= q_rd_data.count;
          held    <= q_rd_data;
          step    <= bbc_pkg::STEP_BITS'(bbc_pkg::SUM_BITS - 1);
          state   <= S_RUN;
        end
        S_RUN: begin
          for (int a = 0; a < bbc_pkg::AXES; a++) begin
            dvd[a] <= dvd_next[a];
            rem[a] <= rem_next[a];
          end
          step <= step - 1'b1;
          if (step == '0) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (hand) begin
            center_x       <= quot[0];
            center_y       <= quot[1];
            center_z       <= quot[2];
            box_min_x      <= held.box_min[0];
            box_min_y      <= held.box_min[1];
            box_min_z      <= held.box_min[2];
            box_max_x      <= held.box_max[0];
            box_max_y      <= held.box_max[1];
            box_max_z      <= held.box_max[2];
            counted_points <= held.count;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CHK_NEXT(a_rd_loads, clk, rst, q_rd, state == S_LOAD, "queue read without load")
  `CHK_NEXT(a_run_ends, clk, rst, state == S_RUN && step == '0, state == S_HOLD, "divider overran")
  `CHK_NEXT(a_hold_hands, clk, rst, state == S_HOLD && (!out_valid || pop), out_valid && state == S_IDLE, "result not handed over")

endmodule

// ===== hw/rtl/bounding_box_and_centroid.sv =====
// Bounding box and centroid of 3-D point sets, top level.
// Depends on bbc_pkg, bbc_front, bbc_fifo and bbc_back.
//
// Usage:
//   Input channel: push a point (point_x/y/z, last_point) when full is low;
//   last_point marks the final point of a set. Points are taken one per
//   cycle; the accumulator keeps no other limit on rate.
//   Result channel: while empty is low the ports carry the oldest result;
//   pulse pop to take it. One result comes per set.
//   The divider handles one set at a time: it loads a record from the queue,
//   runs the bit-per-cycle restoring division of the 32-bit sums, then holds
//   the finished result until the result register is free or being drained.
//   A queue of four finished sets sits between accumulator and divider;
//   full rises only when it holds four sets, and then points wait.
//   When the receiver stalls, the result holds, the divider holds its
//   finished set, and the queue fills behind it.
//   Reset clears the open set, the queue and the valid flag of the result register.
module bounding_box_and_centroid (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [bbc_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [bbc_pkg::COORD_BITS-1:0] point_y,
  input  logic signed [bbc_pkg::COORD_BITS-1:0] point_z,
  input  logic                                  last_point,
  input  logic                                  push,
  output logic                                  full,
  output logic signed [bbc_pkg::COORD_BITS-1:0] center_x,
  output logic signed [bbc_pkg::COORD_BITS-1:0] center_y,
  output logic signed [bbc_pkg::COORD_BITS-1:0] center_z,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_min_x,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_min_y,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_min_z,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_max_x,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_max_y,
  output logic signed [bbc_pkg::COORD_BITS-1:0] box_max_z,
  output logic        [bbc_pkg::CNT_BITS-1:0]   counted_points,
  output logic                                  empty,
  input  logic                                  pop
);

  logic              q_wr;
  logic              q_full;
  logic              q_rd;
  logic              q_empty;
  bbc_pkg::set_rec_t q_wr_data;
  bbc_pkg::set_rec_t q_rd_data;

  bbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_point (last_point),
    .push       (push),
    .full       (full),
    .q_wr       (q_wr),
    .q_wr_data  (q_wr_data),
    .q_full     (q_full)
  );

  bbc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  bbc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_rd           (q_rd),
    .q_rd_data      (q_rd_data),
    .q_empty        (q_empty),
    .center_x       (center_x),
    .center_y       (center_y),
    .center_z       (center_z),
    .box_min_x      (box_min_x),
    .box_min_y      (box_min_y),
    .box_min_z      (box_min_z),
    .box_max_x      (box_max_x),
    .box_max_y      (box_max_y),
    .box_max_z      (box_max_z),
    .counted_points (counted_points),
    .empty          (empty),
    .pop            (pop)
  );

endmodule
